@@ rtl/ffha_pkg.sv @@
// Shared types, constants and command codes of the first-fit heap allocator.
package ffha_pkg;

  localparam int HEAP_BYTES_DEF   = 4096;
  localparam int HEADER_BYTES_DEF = 2;

  localparam int HDR_W    = 16;
  localparam int SIZE_W   = 17;
  localparam int REQ_W    = 16;
  localparam int BOFF_W   = 12;
  localparam int DOFF_W   = 12;
  localparam int LEN_W    = 13;
  localparam int OP_W     = 2;

  localparam int S_TDATA_W = 32;
  localparam int M_TDATA_W = 16;

  localparam logic [LEN_W-1:0]  HEAP_LEN_RST = LEN_W'(4096);
  localparam logic [SIZE_W-1:0] COMPACT_NEED = SIZE_W'(16'hffff);
  localparam logic [SIZE_W-1:0] ALIGN_MASK   = SIZE_W'(3);

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_COMPACT = 2'd2,
    OP_INIT    = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_LOAD,
    CMD_RD_CACHE,
    CMD_RD_PTR,
    CMD_RD_REL,
    CMD_WR_REL,
    CMD_INIT_HEAD,
    CMD_INIT_TAIL,
    CMD_WALK_START,
    CMD_WALK_FREE,
    CMD_WALK_USED,
    CMD_WALK_HIT,
    CMD_WALK_MISS,
    CMD_SPLIT_TAIL,
    CMD_TAKE_ALL,
    CMD_WR_HEAD
  } dp_cmd_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_A_CHK,
    ST_A_RD,
    ST_A_SPLIT,
    ST_A_HEAD,
    ST_R_WR,
    ST_I_TAIL,
    ST_W_RD,
    ST_W_CHK,
    ST_DONE
  } state_e;

  typedef struct packed {
    dp_cmd_e cmd;
    logic    push;
  } ctrl_cmd_t;

  typedef struct packed {
    op_e  op;
    logic req_zero;
    logic cache_vld;
    logic size_gt_hdr;
    logic walk_end;
    logic hdr_used;
    logic run_nz;
    logic run_ge_need;
    logic p_in_heap;
    logic fits;
    logic rel_ok;
    logic len_ge_hb;
  } dp_sts_t;

endpackage

@@ rtl/ffha_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read data.
module ffha_ram #(
  parameter int WIDTH = ffha_pkg::HDR_W,
  parameter int DEPTH = ffha_pkg::HEAP_BYTES_DEF / 2,
  localparam int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [WIDTH-1:0]  wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [WIDTH-1:0]  rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/ffha_dp.sv @@
// Datapath: header store, cached free block, walk registers and result registers.
module ffha_dp #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  ffha_pkg::ctrl_cmd_t           cmd_i,
  output ffha_pkg::dp_sts_t             sts_o,
  input  logic [ffha_pkg::OP_W-1:0]     in_op_i,
  input  logic [ffha_pkg::REQ_W-1:0]    in_req_i,
  input  logic [ffha_pkg::BOFF_W-1:0]   in_boff_i,
  input  logic                          cfg_we_i,
  input  logic [ffha_pkg::LEN_W-1:0]    cfg_wdata_i,
  output logic [ffha_pkg::DOFF_W-1:0]   out_off_o,
  output logic                          out_fail_o
);

  localparam int SLOTS  = HEAP_BYTES / 2;
  localparam int IDX_W  = $clog2(SLOTS);
  localparam int OFF_W  = $clog2(HEAP_BYTES + 1);
  localparam int AW     = ((OFF_W > ffha_pkg::SIZE_W) ? OFF_W : ffha_pkg::SIZE_W) + 1;
  localparam logic [AW-1:0] HB_A    = AW'(HEADER_BYTES);
  localparam logic [AW-1:0] HEAP_A  = AW'(HEAP_BYTES);
  localparam logic [AW-1:0] STORE_A = AW'(2 * SLOTS);
  localparam logic [AW-1:0] CAP_A   = AW'((HEAP_BYTES / 4) * 4);

  localparam int HW = ffha_pkg::HDR_W;
  localparam int SW = ffha_pkg::SIZE_W;

  // control state
  logic                          cache_vld_q, cache_vld_d;
  logic [AW-1:0]                 cache_off_q, cache_off_d;
  logic [ffha_pkg::LEN_W-1:0]    heap_len_q;

  // payload
  ffha_pkg::op_e                 op_q, op_d;
  logic                          req_zero_q, req_zero_d;
  logic [ffha_pkg::BOFF_W-1:0]   boff_q, boff_d;
  logic [SW-1:0]                 size_q, size_d;
  logic [OFF_W-1:0]              p_q, p_d;
  logic [OFF_W-1:0]              best_q, best_d;
  logic [OFF_W-1:0]              run_q, run_d;
  logic [AW-1:0]                 alloc_p_q, alloc_p_d;
  logic [ffha_pkg::DOFF_W-1:0]   res_off_q, res_off_d;
  logic                          res_fail_q, res_fail_d;
  logic [ffha_pkg::DOFF_W-1:0]   out_off_q;
  logic                          out_fail_q;
  logic                          rd_zero_q;

  logic                          rd_en;
  logic [AW-1:0]                 rd_addr;
  logic                          wr_req;
  logic [AW-1:0]                 wr_addr;
  logic [HW-1:0]                 wr_data;
  logic [HW-1:0]                 ram_rdata;
  logic [HW-1:0]                 hdr;
  logic [HW-1:0]                 step;
  logic [AW-1:0]                 p_step;
  logic [AW-1:0]                 rel_addr;
  logic [AW-1:0]                 len_r;
  logic [AW-1:0]                 len_c;
  logic [AW-1:0]                 tail_off;
  logic                          len_ge_hb;
  logic [SW-1:0]                 round_size;

  // reads beyond the store give zero
  assign hdr        = rd_zero_q ? '0 : ram_rdata;
  assign step       = {hdr[HW-1:1], 1'b0};
  assign p_step     = AW'(p_q) + AW'(step);
  assign rel_addr   = AW'(boff_q) - HB_A;
  assign len_r      = AW'({heap_len_q[ffha_pkg::LEN_W-1:2], 2'b00});
  assign len_c      = (len_r > CAP_A) ? CAP_A : len_r;
  assign len_ge_hb  = len_c >= HB_A;
  assign tail_off   = cache_off_q + AW'(size_q);
  assign round_size = (SW'(in_req_i) + ffha_pkg::ALIGN_MASK + SW'(HEADER_BYTES))
                      & ~ffha_pkg::ALIGN_MASK;

  always_comb begin
    sts_o.op          = op_q;
    sts_o.req_zero    = req_zero_q;
    sts_o.cache_vld   = cache_vld_q;
    sts_o.size_gt_hdr = size_q > SW'(hdr);
    sts_o.walk_end    = (step == '0) || (p_step > HEAP_A);
    sts_o.hdr_used    = hdr[0];
    sts_o.run_nz      = run_q != '0;
    sts_o.run_ge_need = AW'(run_q) >= AW'(size_q);
    sts_o.p_in_heap   = AW'(p_q) < HEAP_A;
    sts_o.fits        = AW'(hdr) >= AW'(size_q) + HB_A;
    sts_o.rel_ok      = (AW'(boff_q) >= HB_A) && (rel_addr < STORE_A);
    sts_o.len_ge_hb   = len_ge_hb;
  end

  always_comb begin
    cache_vld_d = cache_vld_q;
    cache_off_d = cache_off_q;
    op_d        = op_q;
    req_zero_d  = req_zero_q;
    boff_d      = boff_q;
    size_d      = size_q;
    p_d         = p_q;
    best_d      = best_q;
    run_d       = run_q;
    alloc_p_d   = alloc_p_q;
    res_off_d   = res_off_q;
    res_fail_d  = res_fail_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_req      = 1'b0;
    wr_addr     = '0;
    wr_data     = '0;
    unique case (cmd_i.cmd)
      ffha_pkg::CMD_NONE: begin
      end
      ffha_pkg::CMD_LOAD: begin
        op_d       = ffha_pkg::op_e'(in_op_i);
        req_zero_d = in_req_i == '0;
        boff_d     = in_boff_i;
        size_d     = (ffha_pkg::op_e'(in_op_i) == ffha_pkg::OP_COMPACT) ?
                     ffha_pkg::COMPACT_NEED : round_size;
        res_off_d  = '0;
        res_fail_d = ffha_pkg::op_e'(in_op_i) == ffha_pkg::OP_ALLOC;
      end
      ffha_pkg::CMD_RD_CACHE: begin
        rd_en   = 1'b1;
        rd_addr = cache_off_q;
      end
      ffha_pkg::CMD_RD_PTR: begin
        rd_en   = 1'b1;
        rd_addr = AW'(p_q);
      end
      ffha_pkg::CMD_RD_REL: begin
        rd_en   = 1'b1;
        rd_addr = rel_addr;
      end
      ffha_pkg::CMD_WR_REL: begin
        wr_req  = 1'b1;
        wr_addr = rel_addr;
        wr_data = {hdr[HW-1:1], 1'b0};
      end
      ffha_pkg::CMD_INIT_HEAD: begin
        wr_req      = 1'b1;
        wr_addr     = '0;
        wr_data     = len_ge_hb ? HW'(len_c - HB_A) : '0;
        cache_off_d = '0;
        cache_vld_d = 1'b1;
      end
      ffha_pkg::CMD_INIT_TAIL: begin
        wr_req  = 1'b1;
        wr_addr = len_c - HB_A;
        wr_data = '0;
      end
      ffha_pkg::CMD_WALK_START: begin
        p_d    = '0;
        best_d = '0;
        run_d  = '0;
      end
      ffha_pkg::CMD_WALK_FREE: begin
        run_d = run_q + OFF_W'(step);
        p_d   = OFF_W'(p_step);
      end
      ffha_pkg::CMD_WALK_USED: begin
        // close the pending run, then skip the used block
        wr_req  = run_q != '0;
        wr_addr = AW'(best_q);
        wr_data = HW'(run_q);
        run_d   = '0;
        p_d     = OFF_W'(p_step);
        best_d  = OFF_W'(p_step);
      end
      ffha_pkg::CMD_WALK_HIT: begin
        wr_req      = 1'b1;
        wr_addr     = AW'(best_q);
        wr_data     = HW'(run_q);
        cache_off_d = AW'(best_q);
        cache_vld_d = 1'b1;
      end
      ffha_pkg::CMD_WALK_MISS: begin
        wr_req      = run_q != '0;
        wr_addr     = AW'(best_q);
        wr_data     = HW'(run_q);
        cache_off_d = '0;
        cache_vld_d = 1'b0;
      end
      ffha_pkg::CMD_SPLIT_TAIL: begin
        wr_req      = 1'b1;
        wr_addr     = tail_off;
        wr_data     = HW'(SW'(hdr) - size_q);
        alloc_p_d   = cache_off_q;
        cache_off_d = tail_off;
      end
      ffha_pkg::CMD_TAKE_ALL: begin
        size_d      = SW'(hdr);
        alloc_p_d   = cache_off_q;
        cache_off_d = '0;
        cache_vld_d = 1'b0;
      end
      ffha_pkg::CMD_WR_HEAD: begin
        wr_req     = 1'b1;
        wr_addr    = alloc_p_q;
        wr_data    = HW'(size_q) | HW'(1);
        res_off_d  = ffha_pkg::DOFF_W'(alloc_p_q + HB_A);
        res_fail_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cache_vld_q <= 1'b0;
      cache_off_q <= '0;
      heap_len_q  <= ffha_pkg::HEAP_LEN_RST;
    end else begin
      cache_vld_q <= cache_vld_d;
      cache_off_q <= cache_off_d;
      if (cfg_we_i) begin
        heap_len_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    req_zero_q <= req_zero_d;
    boff_q     <= boff_d;
    size_q     <= size_d;
    p_q        <= p_d;
    best_q     <= best_d;
    run_q      <= run_d;
    alloc_p_q  <= alloc_p_d;
    res_off_q  <= res_off_d;
    res_fail_q <= res_fail_d;
    if (rd_en) begin
      rd_zero_q <= rd_addr >= STORE_A;
    end
    if (cmd_i.push) begin
      out_off_q  <= res_off_q;
      out_fail_q <= res_fail_q;
    end
  end

  ffha_ram #(
    .WIDTH (HW),
    .DEPTH (SLOTS)
  ) u_hdr_ram (
    .clk_i   (clk_i),
    .we_i    (wr_req && (wr_addr < STORE_A)),
    .waddr_i (wr_addr[IDX_W:1]),
    .wdata_i (wr_data),
    .re_i    (rd_en),
    .raddr_i (rd_addr[IDX_W:1]),
    .rdata_o (ram_rdata)
  );

  assign out_off_o  = out_off_q;
  assign out_fail_o = out_fail_q;

endmodule

@@ rtl/ffha_ctrl.sv @@
// Controller: sequences each operation and the heap walk over the datapath.
module ffha_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  ffha_pkg::dp_sts_t   sts_i,
  output ffha_pkg::ctrl_cmd_t cmd_o
);

  ffha_pkg::state_e state_q, state_d;
  logic             out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ffha_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d      = state_q;
    cmd_o.cmd    = ffha_pkg::CMD_NONE;
    cmd_o.push   = 1'b0;
    in_ready_o   = 1'b0;
    unique case (state_q)
      ffha_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.cmd = ffha_pkg::CMD_LOAD;
          state_d   = ffha_pkg::ST_DISPATCH;
        end
      end
      ffha_pkg::ST_DISPATCH: begin
        unique case (sts_i.op)
          ffha_pkg::OP_ALLOC: begin
            if (sts_i.req_zero) begin
              state_d = ffha_pkg::ST_DONE;
            end else if (!sts_i.cache_vld) begin
              cmd_o.cmd = ffha_pkg::CMD_WALK_START;
              state_d   = ffha_pkg::ST_W_RD;
            end else begin
              cmd_o.cmd = ffha_pkg::CMD_RD_CACHE;
              state_d   = ffha_pkg::ST_A_CHK;
            end
          end
          ffha_pkg::OP_RELEASE: begin
            if (sts_i.rel_ok) begin
              cmd_o.cmd = ffha_pkg::CMD_RD_REL;
              state_d   = ffha_pkg::ST_R_WR;
            end else begin
              state_d = ffha_pkg::ST_DONE;
            end
          end
          ffha_pkg::OP_COMPACT: begin
            cmd_o.cmd = ffha_pkg::CMD_WALK_START;
            state_d   = ffha_pkg::ST_W_RD;
          end
          ffha_pkg::OP_INIT: begin
            cmd_o.cmd = ffha_pkg::CMD_INIT_HEAD;
            state_d   = sts_i.len_ge_hb ? ffha_pkg::ST_I_TAIL : ffha_pkg::ST_DONE;
          end
          default: begin
            state_d = ffha_pkg::ST_DONE;
          end
        endcase
      end
      ffha_pkg::ST_A_CHK: begin
        // cached block too small: fall back to a first-fit walk
        if (sts_i.size_gt_hdr) begin
          cmd_o.cmd = ffha_pkg::CMD_WALK_START;
          state_d   = ffha_pkg::ST_W_RD;
        end else begin
          state_d = ffha_pkg::ST_A_SPLIT;
        end
      end
      ffha_pkg::ST_A_RD: begin
        cmd_o.cmd = ffha_pkg::CMD_RD_CACHE;
        state_d   = ffha_pkg::ST_A_SPLIT;
      end
      ffha_pkg::ST_A_SPLIT: begin
        cmd_o.cmd = sts_i.fits ? ffha_pkg::CMD_SPLIT_TAIL : ffha_pkg::CMD_TAKE_ALL;
        state_d   = ffha_pkg::ST_A_HEAD;
      end
      ffha_pkg::ST_A_HEAD: begin
        cmd_o.cmd = ffha_pkg::CMD_WR_HEAD;
        state_d   = ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_R_WR: begin
        cmd_o.cmd = ffha_pkg::CMD_WR_REL;
        state_d   = ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_I_TAIL: begin
        cmd_o.cmd = ffha_pkg::CMD_INIT_TAIL;
        state_d   = ffha_pkg::ST_DONE;
      end
      ffha_pkg::ST_W_RD, ffha_pkg::ST_W_CHK: begin
        if ((state_q == ffha_pkg::ST_W_RD && !sts_i.p_in_heap) ||
            (state_q == ffha_pkg::ST_W_CHK && sts_i.walk_end)) begin
          // end of heap: close the last run
          if (sts_i.run_nz && sts_i.run_ge_need) begin
            cmd_o.cmd = ffha_pkg::CMD_WALK_HIT;
            state_d   = (sts_i.op == ffha_pkg::OP_ALLOC) ?
                        ffha_pkg::ST_A_RD : ffha_pkg::ST_DONE;
          end else begin
            cmd_o.cmd = ffha_pkg::CMD_WALK_MISS;
            state_d   = ffha_pkg::ST_DONE;
          end
        end else if (state_q == ffha_pkg::ST_W_RD) begin
          cmd_o.cmd = ffha_pkg::CMD_RD_PTR;
          state_d   = ffha_pkg::ST_W_CHK;
        end else if (!sts_i.hdr_used) begin
          cmd_o.cmd = ffha_pkg::CMD_WALK_FREE;
          state_d   = ffha_pkg::ST_W_RD;
        end else if (sts_i.run_nz && sts_i.run_ge_need) begin
          cmd_o.cmd = ffha_pkg::CMD_WALK_HIT;
          state_d   = (sts_i.op == ffha_pkg::OP_ALLOC) ?
                      ffha_pkg::ST_A_RD : ffha_pkg::ST_DONE;
        end else begin
          cmd_o.cmd = ffha_pkg::CMD_WALK_USED;
          state_d   = ffha_pkg::ST_W_RD;
        end
      end
      ffha_pkg::ST_DONE: begin
        // hold until the output register is free or drains this cycle
        if (!out_valid_q || out_ready_i) begin
          cmd_o.push = 1'b1;
          state_d    = ffha_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = ffha_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/first_fit_heap_allocator_unit.sv @@
// First-fit heap allocator: size headers of an implicit heap with lazy coalescing.
//
// Usage: one request enters on the s_axis channel (op in tuser, request size and
// block offset in tdata); exactly one result leaves on m_axis (data offset in
// tdata, failed flag in tuser). heap_length must be written through cfg_we_i only
// while the block is idle; the user is bound to this, the block does not enforce
// it. heap_length is only read by the initialise op. A null release, a zero-size
// allocate or an initialise of an empty heap is finished at dispatch; a release
// reads and then writes the header, an initialise writes the head and then the
// tail, and an allocate served from the cached free block reads it, checks it,
// splits it or takes it whole, then writes its header. A walk over the header RAM
// visits each header with a registered read, then a decision, so an allocate that
// misses the cache, or a coalesce-all, walks the heap. One request is in work
// at a time; the next is taken once the current result is in the output register.
// Reset: the controller returns to idle, the cached free block is dropped and
// heap_length returns to 4096; header RAM contents are undefined until the
// first initialise.
// Stall: a result waits in the output register while m_axis_tready_i is low;
// a following request is accepted and worked, then held until the register
// is free.
module first_fit_heap_allocator_unit #(
  parameter int HEAP_BYTES   = ffha_pkg::HEAP_BYTES_DEF,
  parameter int HEADER_BYTES = ffha_pkg::HEADER_BYTES_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              s_axis_tvalid_i,
  output logic                              s_axis_tready_o,
  // request_size [15:0], block_offset [27:16], zero [31:28]
  input  logic [ffha_pkg::S_TDATA_W-1:0]    s_axis_tdata_i,
  // op [1:0]
  input  logic [ffha_pkg::OP_W-1:0]         s_axis_tuser_i,
  output logic                              m_axis_tvalid_o,
  input  logic                              m_axis_tready_i,
  // data_offset [11:0], zero [15:12]
  output logic [ffha_pkg::M_TDATA_W-1:0]    m_axis_tdata_o,
  // failed [0]
  output logic                              m_axis_tuser_o,
  input  logic                              cfg_we_i,
  input  logic [ffha_pkg::LEN_W-1:0]        cfg_wdata_i
);

  ffha_pkg::ctrl_cmd_t          ctrl_cmd;
  ffha_pkg::dp_sts_t            dp_sts;
  logic [ffha_pkg::DOFF_W-1:0]  out_off;

  ffha_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (dp_sts),
    .cmd_o       (ctrl_cmd)
  );

  ffha_dp #(
    .HEAP_BYTES   (HEAP_BYTES),
    .HEADER_BYTES (HEADER_BYTES)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (ctrl_cmd),
    .sts_o       (dp_sts),
    .in_op_i     (s_axis_tuser_i),
    .in_req_i    (s_axis_tdata_i[ffha_pkg::REQ_W-1:0]),
    .in_boff_i   (s_axis_tdata_i[ffha_pkg::REQ_W +: ffha_pkg::BOFF_W]),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_off_o   (out_off),
    .out_fail_o  (m_axis_tuser_o)
  );

  assign m_axis_tdata_o = ffha_pkg::M_TDATA_W'(out_off);

`ifndef ASSERT_OFF
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !s_axis_tready_o)
    else $error("request accepted while another is in work");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl_cmd.push |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("result pushed over an untaken result");

  a_fail_zero_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("failed allocate carries a non-zero offset");

  a_init_caches: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_cmd.cmd == ffha_pkg::CMD_INIT_HEAD) |=> dp_sts.cache_vld)
    else $error("initialise did not cache the heap block");
`endif

endmodule

@@ bench/tb.sv @@
// Self-checking testbench for the first-fit heap allocator unit.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ffha_pkg::*;

  localparam int HEAP_BYTES   = HEAP_BYTES_DEF;
  localparam int HEADER_BYTES = HEADER_BYTES_DEF;
  localparam int SLOTS        = HEAP_BYTES / 2;

  typedef struct packed {
    logic [DOFF_W-1:0] data_offset;
    logic              failed;
  } alloc_result_t;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_PATTERN, RX_LONG} rx_mode_e;

  // Mirror of the header store and free-block cache; predicts one result per request.
  class heap_scoreboard;
    logic [HDR_W-1:0] headers [SLOTS];
    bit               seen [SLOTS];
    int unsigned      free_off;
    bit               free_vld;
    int unsigned      heap_len;
    alloc_result_t    pending_q [$];
    int               errors;

    function new();
      foreach (headers[i]) begin
        headers[i] = '0;
        seen[i]    = 1'b0;
      end
      free_off = 0;
      free_vld = 1'b0;
      heap_len = HEAP_LEN_RST;
      errors   = 0;
    endfunction

    function int unsigned rd(int unsigned off);
      if ((off >> 1) >= SLOTS) return 0;
      return headers[off >> 1];
    endfunction

    function void wr(int unsigned off, int unsigned val);
      if ((off >> 1) < SLOTS) begin
        headers[off >> 1] = val[15:0];
        seen[off >> 1]    = 1'b1;
      end
    endfunction

    function bit slot_written(int unsigned off);
      return ((off >> 1) < SLOTS) && seen[off >> 1];
    endfunction

    // Merge runs of free blocks from the heap start; stop at the first run of at least need.
    function bit merge_runs(int unsigned need, output int unsigned hit);
      int unsigned p, start, run, h, stride;
      p     = 0;
      start = 0;
      run   = 0;
      hit   = 0;
      while (p < HEAP_BYTES) begin
        h      = rd(p);
        stride = h & ~32'd1;
        if (h == 0 || stride == 0 || p + stride > HEAP_BYTES) break;
        if (h[0]) begin
          if (run != 0) begin
            wr(start, run);
            if (run >= need) begin
              hit = start;
              return 1'b1;
            end
          end
          run   = 0;
          p     = p + stride;
          start = p;
        end else begin
          run = run + stride;
          p   = p + stride;
        end
      end
      if (run != 0) begin
        wr(start, run);
        if (run >= need) begin
          hit = start;
          return 1'b1;
        end
      end
      return 1'b0;
    endfunction

    function alloc_result_t note_request(op_e op, logic [REQ_W-1:0] req,
                                         logic [BOFF_W-1:0] boff);
      alloc_result_t res;
      int unsigned   need, p, avail, hit, len, h;
      bit            ok;
      res.data_offset = '0;
      res.failed      = (op == OP_ALLOC);
      case (op)
        OP_ALLOC: begin
          if (req != 0) begin
            need = (req + 3 + HEADER_BYTES) & ~32'd3;
            ok   = 1'b1;
            if (!free_vld || need > rd(free_off)) begin
              free_vld = merge_runs(need, hit);
              free_off = free_vld ? hit : 0;
              ok       = free_vld;
            end
            if (ok) begin
              p     = free_off;
              avail = rd(p);
              // split off the tail, or hand out the whole block
              if (avail >= need + HEADER_BYTES) begin
                free_off = p + need;
                wr(free_off, avail - need);
              end else begin
                free_vld = 1'b0;
                free_off = 0;
                need     = avail;
              end
              wr(p, need | 1);
              res.data_offset = DOFF_W'(p + HEADER_BYTES);
              res.failed      = 1'b0;
            end
          end
        end
        OP_RELEASE: begin
          if (boff >= HEADER_BYTES) begin
            h = boff - HEADER_BYTES;
            if ((h >> 1) < SLOTS) wr(h, rd(h) & ~32'd1);
          end
        end
        OP_COMPACT: begin
          free_vld = merge_runs(COMPACT_NEED, hit);
          free_off = free_vld ? hit : 0;
        end
        default: begin
          len = heap_len & ~32'd3;
          if (len > (HEAP_BYTES & ~3)) len = HEAP_BYTES & ~3;
          free_off = 0;
          free_vld = 1'b1;
          if (len < HEADER_BYTES) begin
            wr(0, 0);
          end else begin
            wr(0, len - HEADER_BYTES);
            wr(len - HEADER_BYTES, 0);
          end
        end
      endcase
      pending_q.push_back(res);
      return res;
    endfunction

    function void check_result(logic [DOFF_W-1:0] doff, logic fail);
      alloc_result_t want;
      if (pending_q.size() == 0) begin
        $error("unexpected result: data_offset %0d failed %0d", doff, fail);
        errors++;
        return;
      end
      want = pending_q.pop_front();
      if (doff !== want.data_offset) begin
        $error("data_offset mismatch: expected %0d, actual %0d", want.data_offset, doff);
        errors++;
      end
      if (fail !== want.failed) begin
        $error("failed mismatch: expected %0d, actual %0d", want.failed, fail);
        errors++;
      end
    endfunction
  endclass

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic [OP_W-1:0]      s_axis_tuser  = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tuser;
  logic                 cfg_we        = 1'b0;
  logic [LEN_W-1:0]     cfg_wdata     = '0;

  heap_scoreboard    sb;
  logic [DOFF_W-1:0] live_q [$];
  int                burst_left = 0;

  first_fit_heap_allocator_unit DUT (
    .clk_i           (clk),
    .rst_ni          (rst_n),
    .s_axis_tvalid_i (s_axis_tvalid),
    .s_axis_tready_o (s_axis_tready),
    .s_axis_tdata_i  (s_axis_tdata),
    .s_axis_tuser_i  (s_axis_tuser),
    .m_axis_tvalid_o (m_axis_tvalid),
    .m_axis_tready_i (m_axis_tready),
    .m_axis_tdata_o  (m_axis_tdata),
    .m_axis_tuser_o  (m_axis_tuser),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[DOFF_W-1:0], m_axis_tuser);
  end

  // Present one request and hold it until the transfer; gaps fall between bursts.
  task automatic issue(op_e op, logic [REQ_W-1:0] req, logic [BOFF_W-1:0] boff);
    alloc_result_t res;
    if (burst_left == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'h0, boff, req};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    res = sb.note_request(op, req, boff);
    if (op == OP_ALLOC && !res.failed) live_q.push_back(res.data_offset);
    if (op == OP_INIT) live_q.delete();
  endtask

  // Hold the sender until every outstanding result has been taken.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (sb.pending_q.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    burst_left = 0;
  endtask

  initial begin
    rx_mode_e    mode;
    int unsigned span;
    for (;;) begin
      mode = rx_mode_e'($urandom_range(0, 3));
      span = $urandom_range(16, 160);
      for (int unsigned c = 0; c < span; c++) begin
        @(posedge clk);
        case (mode)
          RX_OPEN:    m_axis_tready <= 1'b1;
          RX_RANDOM:  m_axis_tready <= ($urandom_range(0, 3) != 0);
          RX_PATTERN: m_axis_tready <= ((c % 5) < 2);
          default:    m_axis_tready <= ((c % 37) >= 29);
        endcase
      end
    end
  end

  initial begin
    #400_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    logic [REQ_W-1:0]  req;
    logic [BOFF_W-1:0] boff;
    int unsigned       r, eff, span;
    int                idx;
    int                lens [10];

    lens = '{8, 0, 5, 8191, 4096, 0, 0, 0, 0, 0};
    for (int k = 5; k < 10; k++) lens[k] = $urandom_range(8, 512);
    sb = new();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero request and null releases are safe before the heap is formatted
    issue(OP_ALLOC, 16'd0, BOFF_W'($urandom));
    issue(OP_RELEASE, REQ_W'($urandom), 12'd0);
    issue(OP_RELEASE, REQ_W'($urandom), 12'd1);
    issue(OP_INIT, REQ_W'($urandom), BOFF_W'($urandom));
    issue(OP_ALLOC, 16'd1, BOFF_W'($urandom));
    issue(OP_ALLOC, 16'd2, BOFF_W'($urandom));
    issue(OP_ALLOC, 16'd3, BOFF_W'($urandom));
    issue(OP_ALLOC, 16'hffff, BOFF_W'($urandom));
    issue(OP_ALLOC, 16'd0, BOFF_W'($urandom));
    issue(OP_ALLOC, 16'd100, BOFF_W'($urandom));
    issue(OP_ALLOC, 16'd4000, BOFF_W'($urandom));
    issue(OP_RELEASE, REQ_W'($urandom), live_q[1]);
    issue(OP_RELEASE, REQ_W'($urandom), live_q[0] | 12'd1);
    issue(OP_COMPACT, REQ_W'($urandom), BOFF_W'($urandom));
    issue(OP_ALLOC, 16'd4, BOFF_W'($urandom));
    issue(OP_RELEASE, REQ_W'($urandom), 12'd2);
    issue(OP_INIT, REQ_W'($urandom), BOFF_W'($urandom));
    issue(OP_ALLOC, 16'd4094, BOFF_W'($urandom));
    issue(OP_ALLOC, 16'd4090, BOFF_W'($urandom));
    issue(OP_ALLOC, 16'd1, BOFF_W'($urandom));
    issue(OP_RELEASE, REQ_W'($urandom), live_q[0]);
    issue(OP_ALLOC, 16'd4088, BOFF_W'($urandom));
    issue(OP_COMPACT, REQ_W'($urandom), BOFF_W'($urandom));

    for (int ph = 0; ph < 10; ph++) begin
      drain();
      cfg_we    <= 1'b1;
      cfg_wdata <= LEN_W'(lens[ph]);
      @(posedge clk);
      cfg_we      <= 1'b0;
      sb.heap_len  = lens[ph];
      eff = lens[ph] & ~3;
      if (eff > HEAP_BYTES) eff = HEAP_BYTES;
      span = (eff > 8) ? eff : 8;
      issue(OP_INIT, REQ_W'($urandom), BOFF_W'($urandom));
      for (int i = 0; i < 130; i++) begin
        r = $urandom_range(0, 99);
        if (r < 55) begin
          case ($urandom_range(0, 9))
            0:       req = REQ_W'($urandom);
            1:       req = '0;
            2, 3:    req = REQ_W'($urandom_range(1, span));
            default: req = REQ_W'($urandom_range(1, span / 8 + 1));
          endcase
          issue(OP_ALLOC, req, BOFF_W'($urandom));
        end else if (r < 86) begin
          if (live_q.size() != 0 && $urandom_range(0, 9) != 0) begin
            idx  = $urandom_range(0, live_q.size() - 1);
            boff = live_q[idx] | BOFF_W'($urandom_range(0, 1));
            live_q.delete(idx);
          end else begin
            // wild release: only touch slots that hold a defined header value
            boff = BOFF_W'($urandom);
            if (boff >= HEADER_BYTES && !sb.slot_written(boff - HEADER_BYTES))
              boff = BOFF_W'($urandom_range(0, HEADER_BYTES - 1));
          end
          issue(OP_RELEASE, REQ_W'($urandom), boff);
        end else if (r < 95) begin
          issue(OP_COMPACT, REQ_W'($urandom), BOFF_W'($urandom));
        end else begin
          issue(OP_INIT, REQ_W'($urandom), BOFF_W'($urandom));
        end
      end
    end

    drain();
    if (sb.errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

@@ first_fit_heap_allocator_unit.f @@
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_dp.sv
rtl/ffha_ctrl.sv
rtl/first_fit_heap_allocator_unit.sv
bench/tb.sv
